/* design/cfsp_pkg.sv */
// Class file stream parser package: payload structs, phase enum, code constants.
// No dependencies.
package cfsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  record_kind;
        logic [63:0] field_value;
        logic [15:0] pool_slot;
        logic [3:0]  entry_tag;
        logic        field_position;
        logic [2:0]  error_code;
    } out_item_t;

    typedef enum logic [4:0] {
        PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCNT, PH_TAG, PH_OPER, PH_ULEN, PH_UBYTES,
        PH_FLAGS, PH_THIS, PH_SUPER, PH_IFCNT, PH_IFACE, PH_FCNT, PH_MFLAGS, PH_MNAME,
        PH_MDESC, PH_MACNT, PH_ANAME, PH_ALEN, PH_ABYTES, PH_MCNT, PH_CACNT, PH_DONE
    } phase_t;

    localparam logic [4:0] K_MINOR = 5'd0;
    localparam logic [4:0] K_MAJOR = 5'd1;
    localparam logic [4:0] K_PCNT = 5'd2;
    localparam logic [4:0] K_PVAL = 5'd3;
    localparam logic [4:0] K_ULEN = 5'd4;
    localparam logic [4:0] K_FLAGS = 5'd5;
    localparam logic [4:0] K_THIS = 5'd6;
    localparam logic [4:0] K_SUPER = 5'd7;
    localparam logic [4:0] K_IFCNT = 5'd8;
    localparam logic [4:0] K_IFACE = 5'd9;
    localparam logic [4:0] K_FCNT = 5'd10;
    localparam logic [4:0] K_MFLAGS = 5'd11;
    localparam logic [4:0] K_MNAME = 5'd12;
    localparam logic [4:0] K_MDESC = 5'd13;
    localparam logic [4:0] K_MACNT = 5'd14;
    localparam logic [4:0] K_MCNT = 5'd15;
    localparam logic [4:0] K_ANAME = 5'd16;
    localparam logic [4:0] K_ALEN = 5'd17;
    localparam logic [4:0] K_CACNT = 5'd18;
    localparam logic [4:0] K_END = 5'd19;
    localparam logic [4:0] K_BYTE = 5'd20;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_MAGIC = 3'd1;
    localparam logic [2:0] E_TAG = 3'd2;
    localparam logic [2:0] E_INDEX = 3'd3;
    localparam logic [2:0] E_TRUNC = 3'd4;

    localparam logic [3:0] TAG_UTF8 = 4'd1;
    localparam logic [3:0] TAG_INT = 4'd3;
    localparam logic [3:0] TAG_FLOAT = 4'd4;
    localparam logic [3:0] TAG_LONG = 4'd5;
    localparam logic [3:0] TAG_DOUBLE = 4'd6;
    localparam logic [3:0] TAG_CLASS = 4'd7;
    localparam logic [3:0] TAG_FREF = 4'd9;
    localparam logic [3:0] TAG_NAT = 4'd12;

    localparam logic [31:0] MAGIC = 32'hCAFEBABE;

endpackage

/* design/cfsp_step.sv */
// One byte of parser work: next state and the record for this byte, all combinational.
// Depends on cfsp_pkg.
module cfsp_step (
    input  cfsp_pkg::in_item_t  in_item,
    input  cfsp_pkg::phase_t    phase,
    input  logic [2:0]          bif,
    input  logic [63:0]         acc,
    input  logic [15:0]         pool_n,
    input  logic [15:0]         slot,
    input  logic [3:0]          tag,
    input  logic                second,
    input  logic [31:0]         payload,
    input  logic [15:0]         items,
    input  logic [15:0]         attrs,
    input  logic                in_meth,
    input  logic                class_lvl,
    input  logic                halted,
    output cfsp_pkg::phase_t    phase_next,
    output logic [2:0]          bif_next,
    output logic [63:0]         acc_next,
    output logic [15:0]         pool_n_next,
    output logic [15:0]         slot_next,
    output logic [3:0]          tag_next,
    output logic                second_next,
    output logic [31:0]         payload_next,
    output logic [15:0]         items_next,
    output logic [15:0]         attrs_next,
    output logic                in_meth_next,
    output logic                class_lvl_next,
    output logic                halted_next,
    output logic                rec_valid,
    output cfsp_pkg::out_item_t rec
);
    logic [63:0] sh;
    logic [2:0]  cnt1;
    logic [3:0]  need;
    logic        done;
    logic        rec_f;
    logic [4:0]  kind;
    logic [2:0]  err;
    logic        pos;
    logic [15:0] rslot;
    logic [3:0]  rtag;
    logic [63:0] val;
    logic        idx_ok;
    logic        run;
    logic [16:0] nslot;
    logic [15:0] items_dec;
    logic [15:0] attrs_dec;
    logic [31:0] pay_dec;
    cfsp_pkg::phase_t ph;
    logic [2:0]  b0;
    logic [63:0] a0;
    logic [15:0] pn0, sl0, it0, at0;
    logic [3:0]  tg0;
    logic        se0, im0, cl0;
    logic [31:0] py0;

    always_comb begin
        // restart applies the reset state
        if (in_item.start_of_file) begin
            ph = cfsp_pkg::PH_MAGIC; b0 = '0; a0 = '0; pn0 = '0; sl0 = '0; tg0 = '0;
            se0 = 1'b0; py0 = '0; it0 = '0; at0 = '0; im0 = 1'b0; cl0 = 1'b0;
            run = 1'b1;
        end else begin
            ph = phase; b0 = bif; a0 = acc; pn0 = pool_n; sl0 = slot; tg0 = tag;
            se0 = second; py0 = payload; it0 = items; at0 = attrs; im0 = in_meth;
            cl0 = class_lvl; run = !halted && phase != cfsp_pkg::PH_DONE;
        end
    end

    always_comb begin
        sh = {a0[55:0], in_item.data_byte};
        cnt1 = b0 + 3'd1;
        need = 4'd2;
        if (ph == cfsp_pkg::PH_MAGIC || ph == cfsp_pkg::PH_ALEN) need = 4'd4;
        if (ph == cfsp_pkg::PH_OPER) begin
            if (tg0 == cfsp_pkg::TAG_INT || tg0 == cfsp_pkg::TAG_FLOAT) need = 4'd4;
            else if (tg0 == cfsp_pkg::TAG_LONG || tg0 == cfsp_pkg::TAG_DOUBLE) need = 4'd8;
        end
        done = ({1'b0, cnt1} >= need) || (cnt1 == 3'd0);
        idx_ok = (sh != 64'd0) && (sh < {48'd0, pn0});
        items_dec = it0 - 16'd1;
        attrs_dec = at0 - 16'd1;
        pay_dec = py0 - 32'd1;
        if (ph == cfsp_pkg::PH_OPER
            && (tg0 == cfsp_pkg::TAG_LONG || tg0 == cfsp_pkg::TAG_DOUBLE))
            nslot = {1'b0, sl0} + 17'd2;
        else
            nslot = {1'b0, sl0} + 17'd1;
    end

    always_comb begin
        phase_next = ph; bif_next = b0; acc_next = a0; pool_n_next = pn0;
        slot_next = sl0; tag_next = tg0; second_next = se0; payload_next = py0;
        items_next = it0; attrs_next = at0; in_meth_next = im0; class_lvl_next = cl0;
        halted_next = in_item.start_of_file ? 1'b0 : halted;
        rec_f = 1'b0; kind = cfsp_pkg::K_END; err = cfsp_pkg::E_NONE; pos = 1'b0;
        rslot = sl0; rtag = tg0; val = '0;
        if (run) begin
            if (ph != cfsp_pkg::PH_TAG && ph != cfsp_pkg::PH_UBYTES
                && ph != cfsp_pkg::PH_ABYTES) begin
                if (done) begin
                    acc_next = '0; bif_next = '0;
                end else begin
                    acc_next = sh; bif_next = cnt1;
                end
            end
            unique case (ph)
                cfsp_pkg::PH_MAGIC: if (done) begin
                    if (sh[31:0] != cfsp_pkg::MAGIC) begin
                        err = cfsp_pkg::E_MAGIC; val = sh;
                    end else phase_next = cfsp_pkg::PH_MINOR;
                end
                cfsp_pkg::PH_MINOR: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_MINOR; val = sh;
                    phase_next = cfsp_pkg::PH_MAJOR;
                end
                cfsp_pkg::PH_MAJOR: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_MAJOR; val = sh;
                    phase_next = cfsp_pkg::PH_PCNT;
                end
                cfsp_pkg::PH_PCNT: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_PCNT; val = sh;
                    pool_n_next = sh[15:0];
                    if (sh[15:1] == 15'd0) phase_next = cfsp_pkg::PH_FLAGS;
                    else begin
                        slot_next = 16'd1; second_next = 1'b0;
                        phase_next = cfsp_pkg::PH_TAG;
                    end
                end
                cfsp_pkg::PH_TAG: begin
                    if (in_item.data_byte < 8'd1 || in_item.data_byte > 8'd12
                        || in_item.data_byte == 8'd2) begin
                        err = cfsp_pkg::E_TAG; val = {56'd0, in_item.data_byte};
                    end else begin
                        tag_next = in_item.data_byte[3:0];
                        rtag = in_item.data_byte[3:0];
                        second_next = 1'b0;
                        phase_next = (in_item.data_byte[3:0] == cfsp_pkg::TAG_UTF8)
                            ? cfsp_pkg::PH_ULEN : cfsp_pkg::PH_OPER;
                    end
                end
                cfsp_pkg::PH_OPER: begin
                    pos = se0;
                    if (done) begin
                        val = sh;
                        if (tg0 >= cfsp_pkg::TAG_CLASS && !idx_ok) err = cfsp_pkg::E_INDEX;
                        else begin
                            rec_f = 1'b1; kind = cfsp_pkg::K_PVAL;
                            if (tg0 >= cfsp_pkg::TAG_FREF && tg0 <= cfsp_pkg::TAG_NAT
                                && !se0) second_next = 1'b1;
                            else begin
                                second_next = 1'b0;
                                if (nslot >= {1'b0, pn0}) begin
                                    slot_next = '0; tag_next = '0;
                                    phase_next = cfsp_pkg::PH_FLAGS;
                                end else begin
                                    slot_next = nslot[15:0];
                                    phase_next = cfsp_pkg::PH_TAG;
                                end
                            end
                        end
                    end
                end
                cfsp_pkg::PH_ULEN: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_ULEN; val = sh;
                    payload_next = {16'd0, sh[15:0]};
                    if (sh[15:0] == 16'd0) begin
                        second_next = 1'b0;
                        if (nslot >= {1'b0, pn0}) begin
                            slot_next = '0; tag_next = '0; phase_next = cfsp_pkg::PH_FLAGS;
                        end else begin
                            slot_next = nslot[15:0]; phase_next = cfsp_pkg::PH_TAG;
                        end
                    end else phase_next = cfsp_pkg::PH_UBYTES;
                end
                cfsp_pkg::PH_UBYTES: begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_BYTE; pos = 1'b1;
                    val = {56'd0, in_item.data_byte};
                    payload_next = pay_dec;
                    if (pay_dec == 32'd0) begin
                        second_next = 1'b0;
                        if (nslot >= {1'b0, pn0}) begin
                            slot_next = '0; tag_next = '0; phase_next = cfsp_pkg::PH_FLAGS;
                        end else begin
                            slot_next = nslot[15:0]; phase_next = cfsp_pkg::PH_TAG;
                        end
                    end
                end
                cfsp_pkg::PH_FLAGS: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_FLAGS; val = sh;
                    phase_next = cfsp_pkg::PH_THIS;
                end
                cfsp_pkg::PH_THIS: if (done) begin
                    val = sh;
                    if (!idx_ok) err = cfsp_pkg::E_INDEX;
                    else begin
                        rec_f = 1'b1; kind = cfsp_pkg::K_THIS;
                        phase_next = cfsp_pkg::PH_SUPER;
                    end
                end
                cfsp_pkg::PH_SUPER: if (done) begin
                    val = sh;
                    if (sh != 64'd0 && !idx_ok) err = cfsp_pkg::E_INDEX;
                    else begin
                        rec_f = 1'b1; kind = cfsp_pkg::K_SUPER;
                        phase_next = cfsp_pkg::PH_IFCNT;
                    end
                end
                cfsp_pkg::PH_IFCNT: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_IFCNT; val = sh;
                    items_next = sh[15:0];
                    phase_next = (sh[15:0] == 16'd0) ? cfsp_pkg::PH_FCNT
                                                     : cfsp_pkg::PH_IFACE;
                end
                cfsp_pkg::PH_IFACE: if (done) begin
                    val = sh;
                    if (!idx_ok) err = cfsp_pkg::E_INDEX;
                    else begin
                        rec_f = 1'b1; kind = cfsp_pkg::K_IFACE;
                        items_next = items_dec;
                        if (items_dec == 16'd0) phase_next = cfsp_pkg::PH_FCNT;
                    end
                end
                cfsp_pkg::PH_FCNT, cfsp_pkg::PH_MCNT: if (done) begin
                    rec_f = 1'b1; val = sh;
                    kind = (ph == cfsp_pkg::PH_FCNT) ? cfsp_pkg::K_FCNT : cfsp_pkg::K_MCNT;
                    in_meth_next = (ph == cfsp_pkg::PH_MCNT);
                    items_next = sh[15:0];
                    if (sh[15:0] != 16'd0) phase_next = cfsp_pkg::PH_MFLAGS;
                    else phase_next = (ph == cfsp_pkg::PH_MCNT) ? cfsp_pkg::PH_CACNT
                                                                 : cfsp_pkg::PH_MCNT;
                end
                cfsp_pkg::PH_MFLAGS: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_MFLAGS; val = sh;
                    phase_next = cfsp_pkg::PH_MNAME;
                end
                cfsp_pkg::PH_MNAME, cfsp_pkg::PH_MDESC, cfsp_pkg::PH_ANAME: if (done) begin
                    val = sh;
                    if (!idx_ok) err = cfsp_pkg::E_INDEX;
                    else begin
                        rec_f = 1'b1;
                        if (ph == cfsp_pkg::PH_MNAME) begin
                            kind = cfsp_pkg::K_MNAME; phase_next = cfsp_pkg::PH_MDESC;
                        end else if (ph == cfsp_pkg::PH_MDESC) begin
                            kind = cfsp_pkg::K_MDESC; phase_next = cfsp_pkg::PH_MACNT;
                        end else begin
                            kind = cfsp_pkg::K_ANAME; phase_next = cfsp_pkg::PH_ALEN;
                        end
                    end
                end
                cfsp_pkg::PH_MACNT: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_MACNT; val = sh;
                    attrs_next = sh[15:0]; class_lvl_next = 1'b0;
                    if (sh[15:0] != 16'd0) phase_next = cfsp_pkg::PH_ANAME;
                    else begin
                        items_next = items_dec;
                        if (items_dec != 16'd0) phase_next = cfsp_pkg::PH_MFLAGS;
                        else phase_next = im0 ? cfsp_pkg::PH_CACNT : cfsp_pkg::PH_MCNT;
                    end
                end
                cfsp_pkg::PH_CACNT: if (done) begin
                    rec_f = 1'b1; kind = cfsp_pkg::K_CACNT; val = sh;
                    attrs_next = sh[15:0]; class_lvl_next = 1'b1;
                    phase_next = (sh[15:0] == 16'd0) ? cfsp_pkg::PH_DONE
                                                     : cfsp_pkg::PH_ANAME;
                end
                cfsp_pkg::PH_ALEN, cfsp_pkg::PH_ABYTES: begin
                    if (ph == cfsp_pkg::PH_ABYTES || done) begin
                        rec_f = 1'b1;
                        if (ph == cfsp_pkg::PH_ALEN) begin
                            kind = cfsp_pkg::K_ALEN; val = sh; payload_next = sh[31:0];
                        end else begin
                            kind = cfsp_pkg::K_BYTE; val = {56'd0, in_item.data_byte};
                            payload_next = pay_dec;
                        end
                        // attribute finished
                        if ((ph == cfsp_pkg::PH_ALEN && sh[31:0] == 32'd0)
                            || (ph == cfsp_pkg::PH_ABYTES && pay_dec == 32'd0)) begin
                            attrs_next = attrs_dec;
                            if (attrs_dec != 16'd0) phase_next = cfsp_pkg::PH_ANAME;
                            else if (cl0) phase_next = cfsp_pkg::PH_DONE;
                            else begin
                                items_next = items_dec;
                                if (items_dec != 16'd0) phase_next = cfsp_pkg::PH_MFLAGS;
                                else phase_next = im0 ? cfsp_pkg::PH_CACNT
                                                      : cfsp_pkg::PH_MCNT;
                            end
                        end else if (ph == cfsp_pkg::PH_ALEN) begin
                            phase_next = cfsp_pkg::PH_ABYTES;
                        end
                    end
                end
                default: ;
            endcase
            if (err != cfsp_pkg::E_NONE) begin
                rec_f = 1'b1; kind = cfsp_pkg::K_END; halted_next = 1'b1;
            end else if (in_item.end_of_file && phase_next != cfsp_pkg::PH_DONE) begin
                rec_f = 1'b1; kind = cfsp_pkg::K_END; err = cfsp_pkg::E_TRUNC;
                val = '0; halted_next = 1'b1;
            end else if (rec_f && phase_next == cfsp_pkg::PH_DONE) begin
                kind = cfsp_pkg::K_END;
            end
        end
        if (rtag == 4'd0) begin
            rslot = '0; pos = 1'b0;
        end
        rec_valid = rec_f;
        rec.record_kind = kind;
        rec.field_value = val;
        rec.pool_slot = rslot;
        rec.entry_tag = rtag;
        rec.field_position = pos;
        rec.error_code = err;
    end
endmodule

/* design/class_file_stream_parser_core.sv */
// Top level of the class file stream parser: state registers and output register.
// Depends on cfsp_pkg and cfsp_step.
//
//   channel | ports            | payload     | moves
//   input   | s_valid/s_ready  | in_item_t   | one file byte per item
//   result  | m_valid/m_ready  | out_item_t  | zero or one record per byte
//
// One byte per cycle while s_ready is high: each accepted byte updates the parse
// state in the same edge and loads at most one record into the output register.
// s_ready is high while the output register is empty or being taken, so a
// stalled result holds the input only while m_ready is low.
// Reset (aresetn low, synchronous) clears control state; the parser stays
// halted until a byte with start_of_file arrives.
module class_file_stream_parser_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cfsp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cfsp_pkg::out_item_t m_item
);
    cfsp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  bif_reg, bif_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] pool_n_reg, pool_n_next;
    logic [15:0] slot_reg, slot_next;
    logic [3:0]  tag_reg, tag_next;
    logic        second_reg, second_next;
    logic [31:0] payload_reg, payload_next;
    logic [15:0] items_reg, items_next;
    logic [15:0] attrs_reg, attrs_next;
    logic        in_meth_reg, in_meth_next;
    logic        class_lvl_reg, class_lvl_next;
    logic        halted_reg, halted_next;
    logic        rec_valid;
    cfsp_pkg::out_item_t rec;
    logic        m_valid_reg;
    cfsp_pkg::out_item_t m_item_reg;
    logic        take;

    cfsp_step u_step (
        .in_item(s_item), .phase(phase_reg), .bif(bif_reg), .acc(acc_reg),
        .pool_n(pool_n_reg), .slot(slot_reg), .tag(tag_reg), .second(second_reg),
        .payload(payload_reg), .items(items_reg), .attrs(attrs_reg),
        .in_meth(in_meth_reg), .class_lvl(class_lvl_reg), .halted(halted_reg),
        .phase_next(phase_next), .bif_next(bif_next), .acc_next(acc_next),
        .pool_n_next(pool_n_next), .slot_next(slot_next), .tag_next(tag_next),
        .second_next(second_next), .payload_next(payload_next),
        .items_next(items_next), .attrs_next(attrs_next),
        .in_meth_next(in_meth_next), .class_lvl_next(class_lvl_next),
        .halted_next(halted_next), .rec_valid(rec_valid), .rec(rec)
    );

    // output register empty or draining this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign take = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfsp_pkg::PH_MAGIC;
            bif_reg <= '0; acc_reg <= '0; pool_n_reg <= '0; slot_reg <= '0;
            tag_reg <= '0; second_reg <= 1'b0; payload_reg <= '0; items_reg <= '0;
            attrs_reg <= '0; in_meth_reg <= 1'b0; class_lvl_reg <= 1'b0;
            halted_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next; bif_reg <= bif_next; acc_reg <= acc_next;
                pool_n_reg <= pool_n_next; slot_reg <= slot_next; tag_reg <= tag_next;
                second_reg <= second_next; payload_reg <= payload_next;
                items_reg <= items_next; attrs_reg <= attrs_next;
                in_meth_reg <= in_meth_next; class_lvl_reg <= class_lvl_next;
                halted_reg <= halted_next;
            end
            if (s_ready) m_valid_reg <= take && rec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && rec_valid) m_item_reg <= rec;
    end
endmodule
